### rtl/cse_pkg.sv
package cse_pkg;

    localparam int MaxKnots = 64;
    localparam int DataW    = 32;
    localparam int CountW   = 7;
    localparam int OutSegW  = 6;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_SEG,
        OP_CHECK_LO,
        OP_CHECK_HI,
        OP_SEARCH_RD,
        OP_SEARCH_CMP,
        OP_FETCH,
        OP_MUL_E,
        OP_MUL_T1,
        OP_MUL_T2,
        OP_MUL_S,
        OP_FINISH,
        OP_MUL_V,
        OP_VALUE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic search_done;
    } t_status;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [DataW+3:0] v);
        logic signed [DataW+3:0] max_v;
        logic signed [DataW+3:0] min_v;
        max_v = (DataW+4)'(signed'({1'b0, {(DataW-1){1'b1}}}));
        min_v = -max_v - (DataW+4)'(1);
        if (v > max_v) begin
            return {1'b0, {(DataW-1){1'b1}}};
        end else if (v < min_v) begin
            return {1'b1, {(DataW-1){1'b0}}};
        end
        return v[DataW-1:0];
    endfunction

    function automatic logic signed [DataW-1:0] qscale(input logic signed [2*DataW-1:0] p);
        logic signed [2*DataW-1:0] s;
        s = p >>> 16;
        if (s > (2*DataW)'(signed'({1'b0, {(DataW-1){1'b1}}}))) begin
            return {1'b0, {(DataW-1){1'b1}}};
        end else if (s < -(2*DataW)'(signed'({1'b0, {(DataW-1){1'b1}}})) - (2*DataW)'(1)) begin
            return {1'b1, {(DataW-1){1'b0}}};
        end
        return s[DataW-1:0];
    endfunction

endpackage

### rtl/cse_ctrl.sv
module cse_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_cmd,
    input  logic            i_out_stall,
    input  cse_pkg::t_status i_status,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output cse_pkg::t_cmd   o_cmd
);
    import cse_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_CLO, S_CHI, S_SRD, S_SCMP, S_FETCH,
        S_ME, S_MT1, S_MT2, S_MS, S_FIN, S_MV, S_VAL, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd.op    = OP_NONE;
        o_cmd.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_cmd == CMD_EVAL) begin
                    o_cmd.start = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin o_cmd.op = OP_LOAD_SEG; n_state = S_CLO; end
            S_CLO:  begin o_cmd.op = OP_CHECK_LO; n_state = S_CHI; end
            S_CHI: begin
                o_cmd.op = OP_CHECK_HI;
                n_state = S_SRD;
            end
            S_SRD: begin
                if (i_status.hit || i_status.search_done) begin
                    n_state = S_FETCH;
                end else begin
                    o_cmd.op = OP_SEARCH_RD;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin o_cmd.op = OP_SEARCH_CMP; n_state = S_SRD; end
            S_FETCH: begin o_cmd.op = OP_FETCH; n_state = S_ME; end
            S_ME:  begin o_cmd.op = OP_MUL_E;  n_state = S_MT1; end
            S_MT1: begin o_cmd.op = OP_MUL_T1; n_state = S_MT2; end
            S_MT2: begin o_cmd.op = OP_MUL_T2; n_state = S_MS; end
            S_MS:  begin o_cmd.op = OP_MUL_S;  n_state = S_FIN; end
            S_FIN: begin o_cmd.op = OP_FINISH; n_state = S_MV; end
            S_MV:  begin o_cmd.op = OP_MUL_V;  n_state = S_VAL; end
            S_VAL: begin
                o_cmd.op = OP_VALUE;
                n_out_valid = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == S_OUT) else $error("valid outside output state");
    a_busy_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_cmd == CMD_EVAL) |=> o_in_stall)
        else $error("eval not started");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid) else $error("result dropped");
endmodule

### rtl/cse_dp.sv
module cse_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [$clog2(cse_pkg::MaxKnots)-1:0] i_wr_idx,
    input  logic [cse_pkg::OutSegW-1:0] i_entry_index,
    input  logic signed [31:0]         i_knot_x,
    input  logic signed [31:0]         i_knot_y,
    input  logic signed [31:0]         i_coef_b,
    input  logic signed [31:0]         i_coef_c,
    input  logic signed [31:0]         i_coef_d,
    input  logic signed [31:0]         i_query_u,
    input  logic [cse_pkg::CountW-1:0] i_num_knots,
    input  cse_pkg::t_cmd              i_cmd,
    output cse_pkg::t_status           o_status,
    output logic signed [31:0]         o_value,
    output logic signed [31:0]         o_slope,
    output logic signed [31:0]         o_curvature,
    output logic [cse_pkg::OutSegW-1:0] o_segment_index
);
    import cse_pkg::*;

    localparam int IW = $clog2(MaxKnots);
    localparam int NW = $clog2(MaxKnots + 1);

    logic signed [DataW-1:0] m_x [MaxKnots];
    logic signed [DataW-1:0] m_y [MaxKnots];
    logic signed [DataW-1:0] m_b [MaxKnots];
    logic signed [DataW-1:0] m_c [MaxKnots];
    logic signed [DataW-1:0] m_d [MaxKnots];

    logic [IW-1:0] r_cache, r_seg, r_rd_addr, n_rd_addr;
    logic [NW-1:0] r_lo, r_hi, n_mid, r_n;
    logic signed [DataW-1:0] r_u, r_xrd, r_y, r_b, r_c, r_d, r_dx, r_e, r_t, r_c2, r_ts;
    logic signed [DataW-1:0] r_val, r_slp, r_crv;
    logic r_hit, r_done, r_ge;
    logic signed [2*DataW-1:0] r_p1, r_p2;
    logic [NW-1:0] n_cnt;

    always_comb begin
        if (i_num_knots < CountW'(2)) n_cnt = NW'(2);
        else if (32'(i_num_knots) > MaxKnots) n_cnt = NW'(MaxKnots);
        else n_cnt = NW'(i_num_knots);
        n_mid = NW'((NW+1)'(r_lo) + (NW+1)'(r_hi) >> 1);
    end

    always_comb begin
        case (i_cmd.op)
            OP_LOAD_SEG:  n_rd_addr = r_seg;
            OP_CHECK_LO:  n_rd_addr = r_seg + IW'(1);
            OP_SEARCH_RD: n_rd_addr = n_mid[IW-1:0];
            OP_FETCH:     n_rd_addr = r_hit ? r_seg : r_lo[IW-1:0];
            default:      n_rd_addr = r_rd_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            m_x[i_wr_idx] <= i_knot_x;
            m_y[i_wr_idx] <= i_knot_y;
            m_b[i_wr_idx] <= i_coef_b;
            m_c[i_wr_idx] <= i_coef_c;
            m_d[i_wr_idx] <= i_coef_d;
        end
        r_rd_addr <= n_rd_addr;
        r_xrd <= m_x[n_rd_addr];
        r_y   <= m_y[r_seg];
        r_b   <= m_b[r_seg];
        r_c   <= m_c[r_seg];
        r_d   <= m_d[r_seg];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache <= '0;
            r_hit   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_CHECK_LO: begin
                    r_ge <= (r_u >= r_xrd);
                end
                OP_CHECK_HI: begin
                    r_hit <= r_ge && (r_u <= r_xrd);
                end
                OP_SEARCH_CMP: begin
                    if (r_u < r_xrd) r_hi <= n_mid;
                    else r_lo <= n_mid;
                    if ((r_u < r_xrd ? n_mid : r_hi) <= (r_u < r_xrd ? r_lo : n_mid) + NW'(1))
                        r_done <= 1'b1;
                end
                OP_FETCH: begin
                    if (!r_hit) r_seg <= r_lo[IW-1:0];
                end
                OP_MUL_E: begin
                    r_cache <= r_seg;
                    r_dx <= sat32((DataW+4)'(r_u) - (DataW+4)'(r_xrd));
                end
                OP_MUL_T1: begin
                    r_e <= qscale(64'(r_dx) * 64'(r_d));
                end
                OP_MUL_T2: begin
                    r_t  <= sat32((DataW+4)'(r_c) + (DataW+4)'(r_e));
                    r_c2 <= sat32((DataW+4)'(r_c) * 2);
                    r_crv <= sat32((DataW+4)'(sat32((DataW+4)'(r_c) * 2))
                                 + (DataW+4)'(sat32((DataW+4)'(r_e) * 6)));
                    r_ts <= sat32((DataW+4)'(sat32((DataW+4)'(r_c) * 2))
                                 + (DataW+4)'(sat32((DataW+4)'(r_e) * 3)));
                end
                OP_MUL_S: begin
                    r_p1 <= 64'(r_dx) * 64'(r_t);
                    r_p2 <= 64'(r_dx) * 64'(r_ts);
                end
                OP_FINISH: begin
                    r_slp <= sat32((DataW+4)'(r_b) + (DataW+4)'(qscale(r_p2)));
                    r_t   <= sat32((DataW+4)'(r_b) + (DataW+4)'(qscale(r_p1)));
                end
                OP_MUL_V: begin
                    r_p1 <= 64'(r_dx) * 64'(r_t);
                end
                OP_VALUE: begin
                    r_val <= sat32((DataW+4)'(r_y) + (DataW+4)'(qscale(r_p1)));
                end
                default: begin
                    if (i_cmd.start) begin
                        r_u    <= i_query_u;
                        r_n    <= n_cnt;
                        r_lo   <= '0;
                        r_hi   <= n_cnt;
                        r_hit  <= 1'b0;
                        r_done <= (n_cnt <= NW'(1));
                        r_seg  <= (NW'(r_cache) >= n_cnt - NW'(1)) ? '0 : r_cache;
                    end
                end
            endcase
        end
    end

    assign o_status.hit         = r_hit;
    assign o_status.search_done = r_done;
    assign o_value         = r_val;
    assign o_slope         = r_slp;
    assign o_curvature     = r_crv;
    assign o_segment_index = OutSegW'(r_seg);

    logic unused_ok;
    assign unused_ok = ^{i_entry_index, r_n};
endmodule

### rtl/cubic_spline_eval_derivs_core.sv
// Cubic spline evaluator with first and second derivatives, Q16.16.
// Input channel (i_valid/o_stall): i_cmd = 0 writes one knot entry at
// i_entry_index and gives no result; i_cmd = 1 evaluates at i_query_u
// and gives one result on the output channel (o_valid/i_stall).
// An evaluation skips the binary search on a cache hit; otherwise the
// search runs on the single abscissa read port, six halvings for 64
// knots. One evaluation is in flight at a time; o_stall stays high
// until its result is taken. A stalled result holds its value.
// i_cfg_we writes num_knots; the user must write it only while the block
// is idle, and the block itself does not enforce this.
// Reset (synchronous, i_rst_n low) clears the cached segment, sets
// num_knots to 2 and drops any pending result; table contents are kept
// and are undefined until written.
module cubic_spline_eval_derivs_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_cmd,
    input  logic [5:0]                  i_entry_index,
    input  logic signed [31:0]          i_knot_x,
    input  logic signed [31:0]          i_knot_y,
    input  logic signed [31:0]          i_coef_b,
    input  logic signed [31:0]          i_coef_c,
    input  logic signed [31:0]          i_coef_d,
    input  logic signed [31:0]          i_query_u,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_value,
    output logic signed [31:0]          o_slope,
    output logic signed [31:0]          o_curvature,
    output logic [5:0]                  o_segment_index,
    input  logic                        i_cfg_we,
    input  logic [cse_pkg::CountW-1:0]  i_cfg_data
);
    import cse_pkg::*;

    localparam int IW = $clog2(MaxKnots);

    logic [CountW-1:0] r_num_knots;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_num_knots <= CountW'(2);
        else if (i_cfg_we) r_num_knots <= i_cfg_data;
    end

    assign w_wr = i_valid && !o_stall && i_cmd == CMD_WRITE
                  && 32'(i_entry_index) < MaxKnots;

    cse_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (i_valid),
        .i_cmd      (i_cmd),
        .i_out_stall(i_stall),
        .i_status   (w_status),
        .o_in_stall (o_stall),
        .o_out_valid(o_valid),
        .o_cmd      (w_cmd)
    );

    cse_dp u_dp (
        .i_clk, .i_rst_n,
        .i_wr         (w_wr),
        .i_wr_idx     (i_entry_index[IW-1:0]),
        .i_entry_index(i_entry_index),
        .i_knot_x, .i_knot_y, .i_coef_b, .i_coef_c, .i_coef_d, .i_query_u,
        .i_num_knots  (r_num_knots),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_value, .o_slope, .o_curvature, .o_segment_index
    );
endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import cse_pkg::*;

    typedef struct packed {
        logic               cmd;
        logic [5:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] u;
    } t_request;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] slope;
        logic signed [31:0] curvature;
        logic [5:0]         seg;
    } t_spline_point;

    typedef struct packed {
        t_request      rq;
        logic          typed;
        t_spline_point want;
    } t_directed_row;

    localparam int DirRows = 15;
    localparam t_directed_row DIRECTED[DirRows] = '{
        '{'{CMD_WRITE, 6'd0, 32'h0, 32'h00050000, 32'h0, 32'h0, 32'h0, 32'h0},
          1'b0, '{32'h0, 32'h0, 32'h0, 6'd0}},
        '{'{CMD_WRITE, 6'd1, 32'h00010000, 32'hFFFD0000, 32'h0, 32'h0, 32'h0, 32'h0},
          1'b0, '{32'h0, 32'h0, 32'h0, 6'd0}},
        '{'{CMD_EVAL, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          1'b1, '{32'h00050000, 32'h0, 32'h0, 6'd0}},
        '{'{CMD_EVAL, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000},
          1'b1, '{32'h00050000, 32'h0, 32'h0, 6'd0}},
        '{'{CMD_EVAL, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF},
          1'b1, '{32'hFFFD0000, 32'h0, 32'h0, 6'd1}},
        '{'{CMD_EVAL, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000},
          1'b1, '{32'h00050000, 32'h0, 32'h0, 6'd0}},
        '{'{CMD_WRITE, 6'd0, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h0},
          1'b0, '{32'h0, 32'h0, 32'h0, 6'd0}},
        '{'{CMD_EVAL, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00008000},
          1'b1, '{32'h00008000, 32'h00010000, 32'h0, 6'd0}},
        '{'{CMD_WRITE, 6'd0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF, 32'h0}, 1'b0, '{32'h0, 32'h0, 32'h0, 6'd0}},
        '{'{CMD_EVAL, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          1'b0, '{32'h0, 32'h0, 32'h0, 6'd0}},
        '{'{CMD_EVAL, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000},
          1'b0, '{32'h0, 32'h0, 32'h0, 6'd0}},
        '{'{CMD_WRITE, 6'd0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000, 32'h0}, 1'b0, '{32'h0, 32'h0, 32'h0, 6'd0}},
        '{'{CMD_EVAL, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          1'b0, '{32'h0, 32'h0, 32'h0, 6'd0}},
        '{'{CMD_EVAL, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000},
          1'b0, '{32'h0, 32'h0, 32'h0, 6'd0}},
        '{'{CMD_WRITE, 6'd63, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
            32'h7FFFFFFF, 32'h0}, 1'b0, '{32'h0, 32'h0, 32'h0, 6'd0}}
    };

    localparam int NumPhases = 7;
    localparam int PhaseItems = 200;
    localparam int StallLimit = 5000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_cmd;
    logic [5:0]          i_entry_index;
    logic signed [31:0]  i_knot_x;
    logic signed [31:0]  i_knot_y;
    logic signed [31:0]  i_coef_b;
    logic signed [31:0]  i_coef_c;
    logic signed [31:0]  i_coef_d;
    logic signed [31:0]  i_query_u;
    logic                o_valid;
    logic                i_stall;
    logic signed [31:0]  o_value;
    logic signed [31:0]  o_slope;
    logic signed [31:0]  o_curvature;
    logic [5:0]          o_segment_index;
    logic                i_cfg_we;
    logic [CountW-1:0]   i_cfg_data;

    longint          knot_x[MaxKnots];
    longint          knot_y[MaxKnots];
    longint          knot_b[MaxKnots];
    longint          knot_c[MaxKnots];
    longint          knot_d[MaxKnots];
    int unsigned     knot_count;
    int unsigned     cached_seg;
    t_spline_point   expected_points[$];
    bit              quiet;
    int              errors;
    int              evals_checked;
    int              knot_writes;
    int              idle_cycles;

    cubic_spline_eval_derivs_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fxmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clip32(p >>> 16);
    endfunction

    function automatic int unsigned active_knots(input int unsigned n);
        if (n < 2) return 2;
        if (n > MaxKnots) return MaxKnots;
        return n;
    endfunction

    function t_spline_point spline_eval(input longint u);
        int unsigned   n;
        int unsigned   seg;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   mid;
        longint        dx;
        longint        e;
        longint        t;
        longint        c2;
        longint        acc;
        t_spline_point r;
        n = active_knots(knot_count);
        seg = cached_seg;
        if (seg >= n - 1) seg = 0;
        if (!(u >= knot_x[seg] && u <= knot_x[seg + 1])) begin
            lo = 0;
            hi = n;
            while (hi > lo + 1) begin
                mid = (lo + hi) / 2;
                if (u < knot_x[mid]) hi = mid;
                else lo = mid;
            end
            seg = lo;
        end
        cached_seg = seg;
        dx = clip32(u - knot_x[seg]);
        e = fxmul(dx, knot_d[seg]);
        t = clip32(knot_c[seg] + e);
        t = clip32(knot_b[seg] + fxmul(dx, t));
        acc = clip32(knot_y[seg] + fxmul(dx, t));
        r.value = acc[31:0];
        c2 = clip32(2 * knot_c[seg]);
        t = clip32(c2 + clip32(3 * e));
        acc = clip32(knot_b[seg] + fxmul(dx, t));
        r.slope = acc[31:0];
        acc = clip32(c2 + clip32(6 * e));
        r.curvature = acc[31:0];
        r.seg = seg[5:0];
        return r;
    endfunction

    task automatic send_request(input t_request rq, input bit typed, input t_spline_point want);
        t_spline_point pt;
        if (!quiet && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= rq.cmd;
        i_entry_index <= rq.idx;
        i_knot_x      <= rq.x;
        i_knot_y      <= rq.y;
        i_coef_b      <= rq.b;
        i_coef_c      <= rq.c;
        i_coef_d      <= rq.d;
        i_query_u     <= rq.u;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (rq.cmd == CMD_WRITE) begin
            knot_x[rq.idx] = longint'(rq.x);
            knot_y[rq.idx] = longint'(rq.y);
            knot_b[rq.idx] = longint'(rq.b);
            knot_c[rq.idx] = longint'(rq.c);
            knot_d[rq.idx] = longint'(rq.d);
            knot_writes++;
        end else begin
            pt = spline_eval(longint'(rq.u));
            expected_points.push_back(typed ? want : pt);
        end
    endtask

    task automatic set_knot_count(input int unsigned n);
        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n[CountW-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        knot_count = n;
    endtask

    function automatic logic signed [31:0] rand_coef();
        if ($urandom_range(7) == 0) return $urandom;
        return 32'(longint'($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    function automatic logic signed [31:0] pick_query(input int unsigned n);
        longint lo;
        longint span;
        int     r;
        r = $urandom_range(99);
        lo = knot_x[0];
        span = knot_x[n - 1] - lo + 131072;
        if (r < 12) return 32'(knot_x[$urandom_range(n - 1)]);
        if (r < 25 || span <= 0 || span > 64'h1_0000_0000) return $urandom;
        return 32'(clip32(lo - 65536 + longint'($urandom) % span));
    endfunction

    initial begin
        t_request      rq;
        t_spline_point none;
        int unsigned   phase_counts[NumPhases];
        int unsigned   n;
        longint        xcur;
        bit            wide;
        phase_counts = '{64, 2, 127, 0, 20, 64, 9};
        none = '0;
        knot_count = 2;
        cached_seg = 0;
        quiet = 1'b0;
        errors = 0;
        evals_checked = 0;
        knot_writes = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_WRITE;
        i_entry_index = '0;
        i_knot_x = '0;
        i_knot_y = '0;
        i_coef_b = '0;
        i_coef_c = '0;
        i_coef_d = '0;
        i_query_u = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DirRows; i++) begin
            send_request(DIRECTED[i].rq, DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (int ph = 0; ph < NumPhases; ph++) begin
            set_knot_count(phase_counts[ph]);
            n = active_knots(phase_counts[ph]);
            quiet = (ph == 3);
            wide = (ph == 5);
            xcur = wide ? -64'sd2147483648 + $urandom_range(0, 1 << 20)
                        : longint'($urandom_range(0, 1 << 24)) - (1 << 23);
            for (int k = 0; k < n; k++) begin
                rq = '0;
                rq.cmd = CMD_WRITE;
                rq.idx = k[5:0];
                rq.x = 32'(xcur);
                rq.y = rand_coef();
                rq.b = rand_coef();
                rq.c = rand_coef();
                rq.d = rand_coef();
                send_request(rq, 1'b0, none);
                if ($urandom_range(7) == 0) xcur += 1;
                else xcur += wide ? $urandom_range(1, 1 << 25) : $urandom_range(1, 1 << 18);
            end
            for (int k = 0; k < PhaseItems; k++) begin
                rq.cmd = CMD_EVAL;
                rq.idx = 6'($urandom);
                rq.x = $urandom;
                rq.y = $urandom;
                rq.b = $urandom;
                rq.c = $urandom;
                rq.d = $urandom;
                rq.u = pick_query(n);
                if ($urandom_range(99) < 12) rq.cmd = CMD_WRITE;
                send_request(rq, 1'b0, none);
            end
        end

        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("tb: %0d evaluations checked, %0d knot writes", evals_checked, knot_writes);
        $display("tb: knot counts 2, 9, 20, 64 and out-of-range settings 0 and 127");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_spline_point want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_points.size() == 0) begin
                    $error("unexpected result: value %h seg %0d", o_value, o_segment_index);
                    errors++;
                end else begin
                    want = expected_points.pop_front();
                    evals_checked++;
                    if (o_value !== want.value) begin
                        $error("value: expected %h, got %h", want.value, o_value);
                        errors++;
                    end
                    if (o_slope !== want.slope) begin
                        $error("slope: expected %h, got %h", want.slope, o_slope);
                        errors++;
                    end
                    if (o_curvature !== want.curvature) begin
                        $error("curvature: expected %h, got %h", want.curvature, o_curvature);
                        errors++;
                    end
                    if (o_segment_index !== want.seg) begin
                        $error("segment_index: expected %0d, got %0d", want.seg, o_segment_index);
                        errors++;
                    end
                end
            end
            i_stall <= !quiet && ($urandom_range(99) < 26);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= StallLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

### sim.f
rtl/cse_pkg.sv
rtl/cse_ctrl.sv
rtl/cse_dp.sv
rtl/cubic_spline_eval_derivs_core.sv
tb/tb_top.sv
